FILE: hw/rtl/pdve_pkg.sv
`timescale 1ns / 1ps

package pdve_pkg;

	// Width of the value field on the item port
	localparam int IN_VALUE_WIDTH = 32;
	// Default coded value width
	localparam int VALUE_WIDTH_DEF = 32;
	// Payload bits carried by one code byte
	localparam int DIGIT_WIDTH = 7;
	// Reset value of the gap coding switch
	localparam logic DELTA_ENABLE_RST = 1'b1;

	typedef struct packed {
		logic [IN_VALUE_WIDTH-1:0] value;
		logic                      is_frequency;
		logic                      list_start;
	} pdve_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       is_frequency_res;
		logic       last_byte;
	} pdve_res_t;

endpackage

FILE: hw/rtl/pdve_serialiser.sv
`timescale 1ns / 1ps

module pdve_serialiser #(
	parameter int VALUE_WIDTH = pdve_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load_valid,
	input  logic [VALUE_WIDTH-1:0] load_value,
	input  logic                   load_freq,
	output logic                   load_ready,
	output logic                   res_valid,
	input  logic                   res_stall,
	output pdve_pkg::pdve_res_t    res
);
	import pdve_pkg::*;

	logic [VALUE_WIDTH-1:0] sh_q;
	logic                   busy_q;
	logic                   freq_q;
	pdve_res_t              res_q;
	logic                   res_valid_q;

	logic [VALUE_WIDTH-1:0] rest;
	logic                   last;
	logic                   move;
	logic                   load;

	// Peel off the low digit; the byte is final when nothing is left above it
	assign rest = sh_q >> DIGIT_WIDTH;
	assign last = (rest == '0);
	assign move = busy_q && (!res_valid_q || !res_stall);
	assign load_ready = !busy_q || (move && last);
	assign load = load_valid && load_ready;

	// Advance the shift register one digit per transfer into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (move && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q   <= load_value;
			freq_q <= load_freq;
		end else if (move) begin
			sh_q <= rest;
		end
	end

	// Hold the byte until the far side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (move) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q.code_byte        <= {last, sh_q[DIGIT_WIDTH-1:0]};
			res_q.is_frequency_res <= freq_q;
			res_q.last_byte        <= last;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: hw/rtl/posting_delta_varbyte_encoder_unit.sv
`timescale 1ns / 1ps
// An item goes into the shift register, then its bytes into the output register.
// Throughput: one code byte per cycle while res_stall is low; an item codes to 1 to
// ceil(VALUE_WIDTH/7) bytes (5 at 32 bits), peeled off by the 7-bit shifter.
// The next item is taken in the cycle the last byte enters the output register.
// Reset: asynchronous, clears the previous id, enables gap coding, empties the pipe.
module posting_delta_varbyte_encoder_unit #(
	parameter int VALUE_WIDTH = pdve_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic                 wr_data,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  pdve_pkg::pdve_item_t item,
	output logic                 res_valid,
	input  logic                 res_stall,
	output pdve_pkg::pdve_res_t  res
);
	import pdve_pkg::*;

	logic                   delta_en_q;
	logic [VALUE_WIDTH-1:0] prev_id_q;

	logic [VALUE_WIDTH-1:0] v_in;
	logic [VALUE_WIDTH-1:0] prev;
	logic [VALUE_WIDTH-1:0] coded;
	logic                   load_ready;
	logic                   accept;

	// Fit the incoming value to the coded width
	generate
		if (VALUE_WIDTH <= IN_VALUE_WIDTH) begin : g_trunc
			assign v_in = item.value[VALUE_WIDTH-1:0];
		end else begin : g_ext
			assign v_in = {{(VALUE_WIDTH-IN_VALUE_WIDTH){1'b0}}, item.value};
		end
	endgenerate

	// Form the gap against the previous id; frequencies pass unchanged
	always_comb begin
		prev  = item.list_start ? '0 : prev_id_q;
		coded = v_in;
		if (!item.is_frequency && delta_en_q) begin
			coded = v_in - prev;
		end
	end

	assign item_stall = !load_ready;
	assign accept     = item_valid && load_ready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_en_q <= DELTA_ENABLE_RST;
		end else if (wr_en) begin
			delta_en_q <= wr_data;
		end
	end

	// Track the last document id, whether or not gaps are coded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_id_q <= '0;
		end else if (accept && !item.is_frequency) begin
			prev_id_q <= v_in;
		end
	end

	pdve_serialiser #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(item_valid),
		.load_value(coded),
		.load_freq (item.is_frequency),
		.load_ready(load_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
